### hdl/htd_pkg.sv
`default_nettype none

package htd_pkg;

  // Defaults for the top-level parameters.
  localparam int SYMBOL_COUNT_DEF  = 256;
  localparam int MAX_CODE_BITS_DEF = 32;
  localparam int NODE_DEPTH_DEF    = 512;

  // Coded bits carried by one data byte.
  localparam int BYTE_BITS = 8;

  // Width of a child pointer in a node entry.
  localparam int CHILD_W = 9;

  // One node table entry: leaf flag, symbol, right child, left child.
  // A child index of zero means no child, since the root is never a child.
  typedef struct packed {
    logic               leaf;
    logic [7:0]         sym;
    logic [CHILD_W-1:0] right;
    logic [CHILD_W-1:0] left;
  } htd_node_t;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DATA   = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } htd_req_e;

  typedef enum logic [1:0] {
    KIND_SYMBOL  = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_REJECT  = 2'd2,
    KIND_INVALID = 2'd3
  } htd_kind_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  entry_symbol;
    logic [5:0]  code_length;
    logic [31:0] code_bits;
    logic [7:0]  data_byte;
  } htd_in_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] out_symbol;
    logic       last_of_run;
    logic       stream_done;
  } htd_out_t;

  // Requests from the sequencer to the result buffer.
  typedef struct packed {
    logic push;
    logic flush;
  } htd_res_ctl_t;

endpackage

`default_nettype wire

### hdl/htd_node_ram.sv
`default_nettype none

module htd_node_ram import htd_pkg::*; #(
  parameter int DEPTH = NODE_DEPTH_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire htd_node_t                wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output htd_node_t                     rdata_o
);

  htd_node_t mem [DEPTH];
  htd_node_t rdata_q;

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/htd_result_buf.sv
`default_nettype none

module htd_result_buf import htd_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire htd_res_ctl_t ctl_i,
  input  wire htd_out_t     res_i,
  output logic              rdy_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output htd_out_t          out_data_o
);

  // The newest result waits in a holding slot until the next one arrives or
  // the item ends, so that its last flag is known when it moves on.
  logic     pend_valid_q;
  htd_out_t pend_q;
  logic     out_valid_q;
  htd_out_t out_q;
  logic     out_free;
  logic     move;

  assign out_free = !out_valid_q || !out_stall_i;
  assign rdy_o    = !pend_valid_q || out_free;
  assign move     = pend_valid_q && out_free && (ctl_i.push || ctl_i.flush);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (ctl_i.push && rdy_o) begin
        pend_valid_q <= 1'b1;
      end else if (ctl_i.flush && rdy_o) begin
        pend_valid_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push && rdy_o) begin
      pend_q <= res_i;
    end
    if (move) begin
      out_q <= {pend_q.result_kind, pend_q.out_symbol, ctl_i.flush, pend_q.stream_done};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### hdl/huffman_tree_decoder_unit.sv
// Huffman tree decoder. Insert items build a code tree in a node table and
// data bytes are then decoded against it, most significant bit first, with
// one result per decoded symbol or missing child; each insert gives exactly
// one accept or reject result, and clear items empty the table and reload
// the symbol budget from the configuration register. One tree walker,
// built around a node RAM with one read port, one write port and registered
// read data, does all the work, so the block takes one item at a time and
// holds in_stall_o high while it is busy. A data byte is taken, the current
// walk node is fetched (skipped when the walk is at the root), each bit
// then either reads the child node and looks at it or finds a missing
// child, and the byte finishes at the bit-count or budget check and the
// flush. An insert is taken, reads one existing tree level after another,
// finds the branching node, updates it, writes each new node and finishes;
// a rejected insert ends as soon as the conflict is seen. Clear and idle
// items are done as they are taken and never raise in_stall_o. Results
// leave through a holding slot and an output register, so an output stall
// only stops the walker when a result has nowhere to go. Only nodes below
// the fill count are ever read and each is fully written when allocated,
// so the table needs no clearing pass; the root lives in flip-flops.

`default_nettype none

module huffman_tree_decoder_unit import htd_pkg::*; #(
  parameter int SYMBOL_COUNT  = SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
  parameter int NODE_DEPTH    = NODE_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire htd_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output htd_out_t         out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i
);

  localparam int         IdxW     = $clog2(NODE_DEPTH);
  localparam logic [6:0] MaxLen   = 7'(MAX_CODE_BITS);
  localparam logic [8:0] SymLimit = 9'(SYMBOL_COUNT);
  localparam logic [10:0] Depth   = 11'(NODE_DEPTH);

  // Sequencer states. The I_ states build the tree, the D_ states decode.
  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_I_STEP  = 10'b0000000010,
    ST_I_WAIT  = 10'b0000000100,
    ST_I_DIV   = 10'b0000001000,
    ST_I_NEW   = 10'b0000010000,
    ST_D_LOAD  = 10'b0000100000,
    ST_D_LATCH = 10'b0001000000,
    ST_D_BIT   = 10'b0010000000,
    ST_D_LOOK  = 10'b0100000000,
    ST_FLUSH   = 10'b1000000000
  } state_e;

  function automatic logic [CHILD_W-1:0] child_of(htd_node_t n, logic b);
    return b ? n.right : n.left;
  endfunction

  // Code bits above bit 31 read as zero.
  function automatic logic code_bit(logic [31:0] code, logic [5:0] idx);
    return idx[5] ? 1'b0 : code[idx[4:0]];
  endfunction

  state_e      state_q, state_d;
  htd_node_t   root_q, root_d;
  logic [9:0]  nodes_used_q, nodes_used_d;
  logic [CHILD_W-1:0] walk_q, walk_d;
  logic [31:0] symbols_left_q, symbols_left_d;
  logic [31:0] cfg_q, cfg_d;

  htd_node_t   cur_q, cur_d;
  logic [7:0]  sym_q, sym_d;
  logic [31:0] code_q, code_d;
  logic [5:0]  i_q, i_d;
  logic [7:0]  byte_q, byte_d;
  logic [3:0]  bcnt_q, bcnt_d;
  logic [CHILD_W-1:0] ipos_q, ipos_d;

  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  htd_node_t       ram_wdata;
  logic            ram_re;
  logic [IdxW-1:0] ram_raddr;
  htd_node_t       ram_rdata;

  htd_res_ctl_t res_ctl;
  htd_out_t     res;
  logic         buf_rdy;

  // Walker signals for the insert and the decode paths.
  htd_node_t          ins_node;
  htd_node_t          dat_node;
  htd_node_t          div_node;
  htd_node_t          new_node;
  logic               ins_bit;
  logic               ins_bit_next;
  logic [CHILD_W-1:0] ins_child;
  logic [CHILD_W-1:0] dat_child;
  logic [10:0]        need_sum;
  logic [9:0]         nodes_next;
  logic               len_bad;

  assign ins_node     = (ipos_q == '0) ? root_q : cur_q;
  assign dat_node     = (walk_q == '0) ? root_q : cur_q;
  assign ins_bit      = code_bit(code_q, i_q - 6'd1);
  assign ins_bit_next = code_bit(code_q, i_q - 6'd2);
  assign ins_child    = child_of(ins_node, ins_bit);
  assign dat_child    = child_of(dat_node, byte_q[7]);
  // The new nodes of an insert are exactly the steps left at the branch.
  assign need_sum     = 11'(nodes_used_q) + 11'(i_q);
  assign nodes_next   = nodes_used_q + 10'd1;

  assign len_bad = (in_data_i.code_length == '0)
                || ({1'b0, in_data_i.code_length} > MaxLen)
                || ({1'b0, in_data_i.entry_symbol} >= SymLimit);

  // The branching node gains its missing child at the first free index.
  always_comb begin
    div_node = ins_node;
    if (ins_bit) begin
      div_node.right = nodes_used_q[CHILD_W-1:0];
    end else begin
      div_node.left = nodes_used_q[CHILD_W-1:0];
    end
  end

  // A new node is either the leaf or an internal node whose only child is
  // the next index to be allocated.
  always_comb begin
    new_node = '0;
    if (i_q == 6'd1) begin
      new_node.leaf = 1'b1;
      new_node.sym  = sym_q;
    end else if (ins_bit_next) begin
      new_node.right = nodes_next[CHILD_W-1:0];
    end else begin
      new_node.left = nodes_next[CHILD_W-1:0];
    end
  end

  always_comb begin
    state_d        = state_q;
    root_d         = root_q;
    nodes_used_d   = nodes_used_q;
    walk_d         = walk_q;
    symbols_left_d = symbols_left_q;
    cfg_d          = cfg_q;
    cur_d          = cur_q;
    sym_d          = sym_q;
    code_d         = code_q;
    i_d            = i_q;
    byte_d         = byte_q;
    bcnt_d         = bcnt_q;
    ipos_d         = ipos_q;

    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;

    res_ctl           = '0;
    res               = '0;
    res.stream_done   = (symbols_left_q == '0);

    if (cfg_we_i) begin
      cfg_d = cfg_wdata_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.req_type)
            REQ_INSERT: begin
              sym_d  = in_data_i.entry_symbol;
              code_d = in_data_i.code_bits;
              i_d    = in_data_i.code_length;
              ipos_d = '0;
              if (len_bad) begin
                res.result_kind = KIND_REJECT;
                res_ctl.push    = 1'b1;
                state_d         = ST_FLUSH;
              end else begin
                state_d = ST_I_STEP;
              end
            end
            REQ_DATA: begin
              byte_d  = in_data_i.data_byte;
              bcnt_d  = 4'(BYTE_BITS);
              state_d = ST_D_LOAD;
            end
            REQ_CLEAR: begin
              root_d         = '0;
              nodes_used_d   = 10'd1;
              walk_d         = '0;
              symbols_left_d = cfg_q;
            end
            default: begin
            end
          endcase
        end
      end

      // Check pass: one tree level per visit, descending through the RAM.
      ST_I_STEP: begin
        if (ins_node.leaf || ((i_q == 6'd1) && (ins_child != '0))) begin
          res.result_kind = KIND_REJECT;
          res_ctl.push    = 1'b1;
          state_d         = ST_FLUSH;
        end else if ((i_q == 6'd1) || (ins_child == '0)) begin
          if (need_sum > Depth) begin
            res.result_kind = KIND_REJECT;
            res_ctl.push    = 1'b1;
            state_d         = ST_FLUSH;
          end else begin
            state_d = ST_I_DIV;
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ins_child[IdxW-1:0];
          ipos_d    = ins_child;
          i_d       = i_q - 6'd1;
          state_d   = ST_I_WAIT;
        end
      end

      ST_I_WAIT: begin
        cur_d   = ram_rdata;
        state_d = ST_I_STEP;
      end

      ST_I_DIV: begin
        if (ipos_q == '0) begin
          root_d = div_node;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = ipos_q[IdxW-1:0];
          ram_wdata = div_node;
        end
        state_d = ST_I_NEW;
      end

      ST_I_NEW: begin
        ram_we       = 1'b1;
        ram_waddr    = nodes_used_q[IdxW-1:0];
        ram_wdata    = new_node;
        nodes_used_d = nodes_next;
        if (i_q == 6'd1) begin
          res.result_kind = KIND_ACCEPT;
          res_ctl.push    = 1'b1;
          state_d         = ST_FLUSH;
        end else begin
          i_d = i_q - 6'd1;
        end
      end

      // The walk node may have changed through inserts, so fetch it anew.
      ST_D_LOAD: begin
        if (walk_q == '0) begin
          state_d = ST_D_BIT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = walk_q[IdxW-1:0];
          state_d   = ST_D_LATCH;
        end
      end

      ST_D_LATCH: begin
        cur_d   = ram_rdata;
        state_d = ST_D_BIT;
      end

      ST_D_BIT: begin
        if ((bcnt_q == '0) || (symbols_left_q == '0)) begin
          state_d = ST_FLUSH;
        end else if (dat_child == '0) begin
          res.result_kind = KIND_INVALID;
          res_ctl.push    = 1'b1;
          if (buf_rdy) begin
            walk_d = '0;
            bcnt_d = bcnt_q - 4'd1;
            byte_d = {byte_q[6:0], 1'b0};
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = dat_child[IdxW-1:0];
          ipos_d    = dat_child;
          bcnt_d    = bcnt_q - 4'd1;
          byte_d    = {byte_q[6:0], 1'b0};
          state_d   = ST_D_LOOK;
        end
      end

      ST_D_LOOK: begin
        if (ram_rdata.leaf) begin
          res.result_kind = KIND_SYMBOL;
          res.out_symbol  = ram_rdata.sym;
          res.stream_done = (symbols_left_q == 32'd1);
          res_ctl.push    = 1'b1;
          if (buf_rdy) begin
            symbols_left_d = symbols_left_q - 32'd1;
            walk_d         = '0;
            state_d        = ST_D_BIT;
          end
        end else begin
          walk_d  = ipos_q;
          cur_d   = ram_rdata;
          state_d = ST_D_BIT;
        end
      end

      ST_FLUSH: begin
        res_ctl.flush = 1'b1;
        if (buf_rdy) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      root_q         <= '0;
      nodes_used_q   <= 10'd1;
      walk_q         <= '0;
      symbols_left_q <= '0;
      cfg_q          <= '0;
    end else begin
      state_q        <= state_d;
      root_q         <= root_d;
      nodes_used_q   <= nodes_used_d;
      walk_q         <= walk_d;
      symbols_left_q <= symbols_left_d;
      cfg_q          <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    sym_q  <= sym_d;
    code_q <= code_d;
    i_q    <= i_d;
    byte_q <= byte_d;
    bcnt_q <= bcnt_d;
    ipos_q <= ipos_d;
  end

  assign in_stall_o = (state_q != ST_IDLE);

  htd_node_ram #(
    .DEPTH (NODE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  htd_result_buf u_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (res_ctl),
    .res_i       (res),
    .rdy_o       (buf_rdy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### hdl/htd_checker.sv
`default_nettype none

module htd_checker import htd_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_stall_o,
  input wire htd_in_t  in_data_i,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire htd_out_t out_data_o
);

  // An insert or a data byte that is taken leaves the block busy in the cycle after.
  a_busy_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o &&
     (in_data_i.req_type == REQ_INSERT || in_data_i.req_type == REQ_DATA))
    |=> in_stall_o)
    else $error("block took work but was idle in the next cycle");

  // Every insert has a single result, so it always closes its run.
  a_insert_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o &&
     (out_data_o.result_kind == KIND_ACCEPT || out_data_o.result_kind == KIND_REJECT))
    |-> (out_data_o.last_of_run && out_data_o.out_symbol == 8'd0))
    else $error("insert result without last flag or with a symbol");

  // A missing child is only reported while budget remains.
  a_invalid_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.result_kind == KIND_INVALID) |-> !out_data_o.stream_done)
    else $error("invalid code reported with the stream finished");

  // An idle block with an empty output cannot produce a result at once.
  a_no_result_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_stall_o && !out_valid_o) |=> !out_valid_o)
    else $error("result appeared straight out of the idle state");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result transfer changed");

endmodule

bind huffman_tree_decoder_unit htd_checker u_htd_checker (.*);

`default_nettype wire

### tb/testbench.sv
module testbench;
  import htd_pkg::*;

  // The block is built with its default sizes, so the scoreboard model uses
  // the same values.
  localparam int SYMBOL_COUNT  = SYMBOL_COUNT_DEF;
  localparam int MAX_CODE_BITS = MAX_CODE_BITS_DEF;
  localparam int NODE_DEPTH    = NODE_DEPTH_DEF;

  // A long insert walks up to 32 levels, and the settle wait lets any item
  // that is still in flight but owes no result run to its end.
  localparam int SETTLE_CYCLES = 150;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int RUN_LIMIT     = 400000;
  localparam int HOLD_CYCLES   = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  htd_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  htd_out_t    out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  huffman_tree_decoder_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // Model of the decoder state. The node layout is the one from the package,
  // and an index of zero in a child field means that the child is missing.
  htd_node_t   node_mem [NODE_DEPTH];
  int          fill_count;
  logic [8:0]  walk_node;
  logic [31:0] budget_left;
  logic [31:0] budget_reg;

  // Results the model has produced that the block has not yet delivered,
  // oldest first.
  htd_out_t    results_due [$];
  htd_out_t    want_result;
  int          error_count = 0;

  // Idling controls. The percentages are the chance, per cycle, that the
  // sender leaves a gap before its next transfer or that the receiver stalls.
  // A nonzero hold count makes the receiver stall until the count runs down.
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;

  // ---------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------

  function automatic htd_out_t make_result(input logic [1:0] kind, input logic [7:0] sym);
    htd_out_t r;
    r.result_kind = kind;
    r.out_symbol  = sym;
    r.last_of_run = 1'b0;
    r.stream_done = (budget_left == 0);
    return r;
  endfunction

  // Adds one code to the model tree. The first pass only checks, so a
  // rejected code leaves the tree exactly as it was. A code is rejected when
  // its length is out of range, when its path runs through a leaf, when its
  // end node already exists, or when the table lacks room for its new nodes.
  function automatic bit insert_code(input logic [7:0] sym, input int len,
                                     input logic [31:0] bits);
    int         pos;
    int         need;
    int         i;
    logic [8:0] c;
    htd_node_t  n;
    if (len == 0 || len > MAX_CODE_BITS || sym >= SYMBOL_COUNT) return 1'b0;
    pos  = 0;
    need = 0;
    for (i = len; i > 0; i--) begin
      n = node_mem[pos];
      if (n.leaf) return 1'b0;
      c = bits[i-1] ? n.right : n.left;
      if (i == 1) begin
        if (c != 0) return 1'b0;
        need = 1;
      end else if (c == 0) begin
        need = i;
        break;
      end else begin
        pos = int'(c);
      end
    end
    if (fill_count + need > NODE_DEPTH) return 1'b0;
    pos = 0;
    for (i = len; i > 0; i--) begin
      n = node_mem[pos];
      c = bits[i-1] ? n.right : n.left;
      if (c == 0) begin
        c = 9'(fill_count);
        fill_count++;
        n = '0;
        if (i == 1) begin
          n.leaf = 1'b1;
          n.sym  = sym;
        end
        node_mem[c] = n;
        n = node_mem[pos];
        if (bits[i-1]) n.right = c;
        else n.left = c;
        node_mem[pos] = n;
      end
      pos = int'(c);
    end
    return 1'b1;
  endfunction

  // Applies one accepted item to the model and queues the results it causes.
  function automatic void huffman_step(input htd_in_t item);
    htd_out_t   res [8];
    htd_out_t   r;
    int         k;
    int         i;
    logic [8:0] c;
    htd_node_t  n;
    k = 0;
    case (item.req_type)
      REQ_INSERT: begin
        if (insert_code(item.entry_symbol, int'(item.code_length), item.code_bits))
          res[0] = make_result(KIND_ACCEPT, 8'h00);
        else
          res[0] = make_result(KIND_REJECT, 8'h00);
        k = 1;
      end
      REQ_CLEAR: begin
        for (i = 0; i < NODE_DEPTH; i++) node_mem[i] = '0;
        fill_count  = 1;
        walk_node   = '0;
        budget_left = budget_reg;
      end
      REQ_DATA: begin
        // Once the budget runs out, the rest of the byte is dropped.
        for (i = 7; i >= 0; i--) begin
          if (budget_left == 0) break;
          n = node_mem[walk_node];
          c = item.data_byte[i] ? n.right : n.left;
          if (c == 0) begin
            walk_node = '0;
            res[k] = make_result(KIND_INVALID, 8'h00);
            k++;
          end else if (node_mem[c].leaf) begin
            walk_node = '0;
            budget_left--;
            res[k] = make_result(KIND_SYMBOL, node_mem[c].sym);
            k++;
          end else begin
            walk_node = c;
          end
        end
      end
      default: ;
    endcase
    for (i = 0; i < k; i++) begin
      r = res[i];
      r.last_of_run = (i == k - 1);
      results_due.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------

  // The receiver stalls at random, or without a break while a hold is
  // running. The hold is counted here so that the sender keeps offering
  // items in the meantime.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Every result transfer is compared against the oldest queued result.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (results_due.size() == 0) begin
        if (error_count < 10)
          $display("Unexpected result: kind %0d symbol %02h last %0b done %0b",
                   out_data_o.result_kind, out_data_o.out_symbol,
                   out_data_o.last_of_run, out_data_o.stream_done);
        error_count++;
      end else begin
        want_result = results_due.pop_front();
        if (out_data_o.result_kind !== want_result.result_kind ||
            out_data_o.out_symbol  !== want_result.out_symbol  ||
            out_data_o.last_of_run !== want_result.last_of_run ||
            out_data_o.stream_done !== want_result.stream_done) begin
          if (error_count < 10)
            $display({"Result mismatch: expected kind %0d symbol %02h last %0b done %0b,",
                      " got kind %0d symbol %02h last %0b done %0b"},
                     want_result.result_kind, want_result.out_symbol,
                     want_result.last_of_run, want_result.stream_done,
                     out_data_o.result_kind, out_data_o.out_symbol,
                     out_data_o.last_of_run, out_data_o.stream_done);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Fields that the item kind does not use still carry random values, so that
  // the block is seen to ignore them.
  function automatic htd_in_t random_item(input logic [1:0] kind);
    htd_in_t it;
    it.req_type     = kind;
    it.entry_symbol = 8'($urandom);
    it.code_length  = 6'($urandom);
    it.code_bits    = $urandom;
    it.data_byte    = 8'($urandom);
    return it;
  endfunction

  // Offers one item, after a random gap, and holds it until the block takes
  // it. Valid is only ever changed once per clock edge: a gap lowers it, a
  // new item raises it, and back-to-back items simply leave it high.
  task automatic send_item(input htd_in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    huffman_step(item);
  endtask

  task automatic send_code(input logic [7:0] sym, input int len, input logic [31:0] bits);
    htd_in_t it;
    it              = random_item(REQ_INSERT);
    it.entry_symbol = sym;
    it.code_length  = 6'(len);
    it.code_bits    = bits;
    send_item(it);
  endtask

  task automatic send_byte(input logic [7:0] value);
    htd_in_t it;
    it           = random_item(REQ_DATA);
    it.data_byte = value;
    send_item(it);
  endtask

  // Stops sending, waits until every queued result has arrived, and then lets
  // the block finish any item that owes no result. After this the block is
  // idle and the budget register may be written.
  task automatic wait_drained();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (results_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (results_due.size() != 0) begin
      if (error_count < 10)
        $display("%0d expected results never arrived", results_due.size());
      error_count++;
      results_due.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_symbol_budget(input logic [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    budget_reg = value;
  endtask

  // Idling modes: none, sender gaps, receiver stalls, and light idling on
  // both sides.
  task automatic set_idling(input int mode);
    case (mode)
      1:       begin send_idle_pct = 66; stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  stall_pct = 66; end
      3:       begin send_idle_pct = 6;  stall_pct = 6;  end
      default: begin send_idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // Inserts a complete prefix code of n entries, built by splitting random
  // leaves of a two-leaf tree, so that any bit stream decodes. Dropping one
  // entry leaves a hole that turns into invalid code results. Bits above each
  // code's length are random and must be ignored.
  task automatic send_random_code_set(input int n, input bit drop_one);
    logic [31:0] val [16];
    int          len [16];
    int          count;
    int          idx;
    int          skip;
    int          i;
    val[0] = 32'd0;
    len[0] = 1;
    val[1] = 32'd1;
    len[1] = 1;
    count  = 2;
    while (count < n) begin
      idx        = $urandom_range(count - 1);
      val[count] = (val[idx] << 1) | 32'd1;
      len[count] = len[idx] + 1;
      val[idx]   = val[idx] << 1;
      len[idx]   = len[idx] + 1;
      count++;
    end
    skip = drop_one ? $urandom_range(count - 1) : -1;
    for (i = 0; i < count; i++) begin
      if (i != skip)
        send_code(8'($urandom_range(255)), len[i], val[i] | ($urandom << len[i]));
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Hand-built trees that hit every insert rejection but a full table, decoding
  // across byte boundaries, an insert between two data bytes, the budget running
  // out inside a byte, a zero and a full budget, and a byte with eight results.
  task automatic test_directed_codes();
    set_idling(0);
    set_symbol_budget(32'd5);
    send_item(random_item(REQ_NONE));
    send_item(random_item(REQ_CLEAR));
    send_code(8'h41, 1, 32'h0);          // code 0
    send_code(8'h00, 2, 32'h2);          // code 10
    send_code(8'hFF, 3, 32'h6);          // code 110, leaves 111 missing
    send_code(8'h11, 0, 32'h0);          // zero length
    send_code(8'h12, 33, $urandom);      // one bit too long
    send_code(8'h13, 63, $urandom);      // longest encodable length
    send_code(8'h14, 2, 32'h1);          // path runs through leaf 0
    send_code(8'h15, 1, 32'h1);          // ends on internal node 1
    send_code(8'h16, 2, 32'h2);          // duplicate of 10
    // Three symbols, then the walk is left part way down at node 11.
    send_byte(8'b0101_1011);
    // The walk position must survive this insert of 1110.
    send_code(8'h7E, 4, 32'hFFFF_FFFE);
    // Finishes 1110, then one more symbol uses up the budget mid-byte.
    send_byte(8'b1000_0000);
    send_byte(8'h00);                    // budget is spent, nothing comes out

    wait_drained();
    set_symbol_budget(32'd0);
    send_item(random_item(REQ_CLEAR));
    send_code(8'h20, 1, 32'h0);
    send_byte(8'h00);                    // zero budget, ignored

    wait_drained();
    set_symbol_budget(32'hFFFF_FFFF);
    send_item(random_item(REQ_CLEAR));
    send_code(8'hC3, 32, 32'h8000_0001); // full-length code
    send_code(8'h3C, 1, 32'h0);
    send_byte(8'hFF);                    // missing children below node 1
    send_byte(8'h00);                    // eight symbols from one byte
  endtask

  // Long random codes until the node table runs out of room, then decoding
  // through the deep tree.
  task automatic test_table_full();
    int i;
    set_idling(3);
    wait_drained();
    set_symbol_budget(32'd3);
    send_item(random_item(REQ_CLEAR));
    for (i = 0; i < 24; i++) send_code(8'($urandom_range(255)), 32, $urandom);
    send_code(8'($urandom_range(255)), $urandom_range(3, 1), $urandom);
    for (i = 0; i < 4; i++) send_byte(8'($urandom_range(255)));
  endtask

  // The receiver holds off for a long stretch while the sender keeps going,
  // so the result path backs up into the input.
  task automatic test_output_hold();
    int i;
    set_idling(0);
    wait_drained();
    set_symbol_budget(32'hFFFF_FFFF);
    send_item(random_item(REQ_CLEAR));
    send_random_code_set(4, 1'b0);
    hold_left = HOLD_CYCLES;
    for (i = 0; i < 12; i++) send_byte(8'($urandom_range(255)));
    wait_drained();
  endtask

  // Mostly well-formed streams: clear, a code set, then data bytes, with the
  // budget varied between streams. Some streams skip the clear, some codes
  // are left out, and random inserts and empty items are mixed in.
  task automatic test_random_streams();
    int          s;
    int          b;
    logic [31:0] budget;
    for (s = 0; s < 4; s++) begin
      set_idling(s % 4);
      wait_drained();
      case ($urandom_range(7))
        0:       budget = 32'hFFFF_FFFF;
        1:       budget = $urandom;
        default: budget = $urandom_range(60, 4);
      endcase
      set_symbol_budget(budget);
      if ($urandom_range(7) != 0) send_item(random_item(REQ_CLEAR));
      send_random_code_set($urandom_range(10, 2), $urandom_range(2) == 0);
      // Now and then the sender waits for every result before going on.
      if ($urandom_range(3) == 0) wait_drained();
      for (b = $urandom_range(6, 3); b > 0; b--) begin
        case ($urandom_range(9))
          0:       send_code(8'($urandom_range(255)), $urandom_range(63), $urandom);
          1:       send_item(random_item(REQ_NONE));
          default: send_byte(8'($urandom_range(255)));
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence and end of run
  // ---------------------------------------------------------------------

  initial begin
    for (int i = 0; i < NODE_DEPTH; i++) node_mem[i] = '0;
    fill_count  = 1;
    walk_node   = '0;
    budget_left = '0;
    budget_reg  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_codes();
    test_table_full();
    test_output_hold();
    test_random_streams();
    wait_drained();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // A run that hangs, for instance on a transfer that never completes, ends
  // here as a failure.
  initial begin
    #(RUN_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### files.f
hdl/htd_pkg.sv
hdl/htd_node_ram.sv
hdl/htd_result_buf.sv
hdl/huffman_tree_decoder_unit.sv
hdl/htd_checker.sv
tb/testbench.sv
